// ----- sv/assert_macros.svh -----
// Assertion macros shared by the canyon solver RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication on clk, masked during reset
`define CMRS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication on clk, masked during reset
`define CMRS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- sv/cmrs_pkg.sv -----
// Shared types, constants and the operation sequence of the canyon solver
package cmrs_pkg;

	localparam int unsigned RAD_W      = 32;
	localparam int unsigned FAC_W      = 17;
	localparam int unsigned HW_W       = 16;
	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned STEP_W     = 6;
	localparam int unsigned RF_DEPTH   = 19;
	localparam int unsigned OUT_NUM    = 8;

	localparam logic [FAC_W-1:0] Q16_ONE   = 17'd65536;
	localparam logic [RAD_W-1:0] ERR_LIMIT = 32'd2685;
	localparam logic [RAD_W-1:0] ALL_ONES  = 32'hFFFF_FFFF;

	// Configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] CFG_HW  = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_VWR = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_VRW = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_VWW = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_WP  = 3'd4;

	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_LOOP_FIRST = 6'd17;
	localparam step_t STEP_LOOP_LAST  = 6'd49;
	localparam step_t STEP_OUT_FIRST  = 6'd50;
	localparam step_t STEP_LAST       = 6'd57;

	// Register file slots; the eight totals come first in output order
	typedef enum logic [4:0] {
		RF_ABS_I, RF_ABS_P, RF_ABS_S, RF_ABS_D,
		RF_REF_I, RF_REF_P, RF_REF_S, RF_REF_D,
		RF_RTW, RF_S2R, RF_S2O, RF_D2R, RF_D2O,
		RF_T0, RF_T1, RF_T2, RF_T3, RF_T4, RF_T5
	} rf_addr_t;

	typedef enum logic [2:0] {OP_MUL, OP_MULHW, OP_ADD, OP_DIV, OP_OUT} op_kind_t;

	typedef enum logic [3:0] {
		FAC_AI, FAC_NAI, FAC_AP, FAC_NAP, FAC_AS, FAC_NAS, FAC_AD, FAC_NAD,
		FAC_WP, FAC_WI, FAC_VWR, FAC_VRW, FAC_VWW, FAC_HW
	} fac_t;

	typedef enum logic [1:0] {EXT_NONE, EXT_R, EXT_S, EXT_D} ext_t;

	typedef enum logic [1:0] {CRIT_KEEP, CRIT_LOAD, CRIT_MAX} crit_t;

	typedef struct packed {
		op_kind_t kind;
		rf_addr_t dst;
		rf_addr_t src_a;
		rf_addr_t src_b;
		ext_t     ext;
		fac_t     fac;
		crit_t    crit;
	} op_t;

	typedef struct packed {
		op_t  op;
		logic capture;
		logic rd;
		logic ex;
		logic div_wr;
	} cmrs_cmd_t;

	typedef struct packed {
		logic div_done;
		logic crit_low;
	} cmrs_stat_t;

	function automatic op_t u_mul(rf_addr_t dst, rf_addr_t a, fac_t f);
		op_t o;
		o = '{kind: OP_MUL, dst: dst, src_a: a, src_b: RF_T0, ext: EXT_NONE, fac: f,
			crit: CRIT_KEEP};
		return o;
	endfunction

	function automatic op_t u_mule(rf_addr_t dst, ext_t e, fac_t f);
		op_t o;
		o = '{kind: OP_MUL, dst: dst, src_a: RF_T0, src_b: RF_T0, ext: e, fac: f,
			crit: CRIT_KEEP};
		return o;
	endfunction

	function automatic op_t u_add(rf_addr_t dst, rf_addr_t a, rf_addr_t b, crit_t c);
		op_t o;
		o = '{kind: OP_ADD, dst: dst, src_a: a, src_b: b, ext: EXT_NONE, fac: FAC_AI,
			crit: c};
		return o;
	endfunction

	function automatic op_t u_mhw(rf_addr_t dst, rf_addr_t a);
		op_t o;
		o = '{kind: OP_MULHW, dst: dst, src_a: a, src_b: RF_T0, ext: EXT_NONE, fac: FAC_HW,
			crit: CRIT_KEEP};
		return o;
	endfunction

	function automatic op_t u_div(rf_addr_t dst, rf_addr_t a);
		op_t o;
		o = '{kind: OP_DIV, dst: dst, src_a: a, src_b: RF_T0, ext: EXT_NONE, fac: FAC_HW,
			crit: CRIT_KEEP};
		return o;
	endfunction

	function automatic op_t u_out(rf_addr_t a);
		op_t o;
		o = '{kind: OP_OUT, dst: RF_T0, src_a: a, src_b: RF_T0, ext: EXT_NONE, fac: FAC_AI,
			crit: CRIT_KEEP};
		return o;
	endfunction

	// Operation sequence: first hit, exchange pass, readout
	function automatic op_t ucode(step_t step);
		op_t o;
		unique case (step)
			6'd0:  o = u_mule(RF_ABS_I, EXT_R, FAC_NAI);
			6'd1:  o = u_mule(RF_REF_I, EXT_R, FAC_AI);
			6'd2:  o = u_mule(RF_ABS_P, EXT_R, FAC_NAP);
			6'd3:  o = u_mule(RF_REF_P, EXT_R, FAC_AP);
			6'd4:  o = u_mule(RF_ABS_S, EXT_S, FAC_NAS);
			6'd5:  o = u_mule(RF_REF_S, EXT_S, FAC_AS);
			6'd6:  o = u_mule(RF_ABS_D, EXT_D, FAC_NAD);
			6'd7:  o = u_mule(RF_REF_D, EXT_D, FAC_AD);
			6'd8:  o = u_mul(RF_T0, RF_REF_I, FAC_VWR);
			6'd9:  o = u_mul(RF_T0, RF_T0, FAC_WI);
			6'd10: o = u_mul(RF_T1, RF_REF_P, FAC_VWR);
			6'd11: o = u_mul(RF_T1, RF_T1, FAC_WP);
			6'd12: o = u_add(RF_RTW, RF_T0, RF_T1, CRIT_KEEP);
			6'd13: o = u_mul(RF_S2R, RF_REF_S, FAC_VRW);
			6'd14: o = u_mul(RF_S2O, RF_REF_S, FAC_VWW);
			6'd15: o = u_mul(RF_D2R, RF_REF_D, FAC_VRW);
			6'd16: o = u_mul(RF_D2O, RF_REF_D, FAC_VWW);
			// exchange pass
			6'd17: o = u_add(RF_T0, RF_S2R, RF_D2R, CRIT_KEEP);
			6'd18: o = u_mhw(RF_T0, RF_T0);
			6'd19: o = u_mul(RF_T1, RF_T0, FAC_NAI);
			6'd20: o = u_mul(RF_T2, RF_T0, FAC_AI);
			6'd21: o = u_mul(RF_T3, RF_T0, FAC_NAP);
			6'd22: o = u_mul(RF_T4, RF_T0, FAC_AP);
			6'd23: o = u_mul(RF_T0, RF_T1, FAC_WI);
			6'd24: o = u_mul(RF_T5, RF_T3, FAC_WP);
			6'd25: o = u_add(RF_T0, RF_T0, RF_T5, CRIT_LOAD);
			6'd26: o = u_add(RF_ABS_I, RF_ABS_I, RF_T1, CRIT_KEEP);
			6'd27: o = u_add(RF_ABS_P, RF_ABS_P, RF_T3, CRIT_KEEP);
			6'd28: o = u_div(RF_T0, RF_RTW);
			6'd29: o = u_add(RF_T1, RF_T0, RF_D2O, CRIT_KEEP);
			6'd30: o = u_add(RF_T3, RF_T0, RF_S2O, CRIT_KEEP);
			6'd31: o = u_mul(RF_T5, RF_T1, FAC_NAS);
			6'd32: o = u_add(RF_ABS_S, RF_ABS_S, RF_T5, CRIT_MAX);
			6'd33: o = u_mul(RF_T1, RF_T1, FAC_AS);
			6'd34: o = u_mul(RF_T5, RF_T3, FAC_NAD);
			6'd35: o = u_add(RF_ABS_D, RF_ABS_D, RF_T5, CRIT_MAX);
			6'd36: o = u_mul(RF_T3, RF_T3, FAC_AD);
			6'd37: o = u_mul(RF_T0, RF_T2, FAC_VWR);
			6'd38: o = u_mul(RF_T0, RF_T0, FAC_WI);
			6'd39: o = u_mul(RF_T5, RF_T4, FAC_VWR);
			6'd40: o = u_mul(RF_T5, RF_T5, FAC_WP);
			6'd41: o = u_add(RF_RTW, RF_T0, RF_T5, CRIT_KEEP);
			6'd42: o = u_mul(RF_S2R, RF_T1, FAC_VRW);
			6'd43: o = u_mul(RF_S2O, RF_T1, FAC_VWW);
			6'd44: o = u_mul(RF_D2R, RF_T3, FAC_VRW);
			6'd45: o = u_mul(RF_D2O, RF_T3, FAC_VWW);
			6'd46: o = u_add(RF_REF_I, RF_REF_I, RF_T2, CRIT_KEEP);
			6'd47: o = u_add(RF_REF_P, RF_REF_P, RF_T4, CRIT_KEEP);
			6'd48: o = u_add(RF_REF_S, RF_REF_S, RF_T1, CRIT_KEEP);
			6'd49: o = u_add(RF_REF_D, RF_REF_D, RF_T3, CRIT_KEEP);
			// readout
			6'd50: o = u_out(RF_ABS_I);
			6'd51: o = u_out(RF_ABS_P);
			6'd52: o = u_out(RF_ABS_S);
			6'd53: o = u_out(RF_ABS_D);
			6'd54: o = u_out(RF_REF_I);
			6'd55: o = u_out(RF_REF_P);
			6'd56: o = u_out(RF_REF_S);
			6'd57: o = u_out(RF_REF_D);
			default: o = u_out(RF_ABS_I);
		endcase
		return o;
	endfunction

	// Limit a Q1.16 factor to one
	function automatic logic [FAC_W-1:0] clamp_q16(logic [FAC_W-1:0] v);
		return (v > Q16_ONE) ? Q16_ONE : v;
	endfunction

endpackage

// ----- sv/cmrs_div.sv -----
// Radix-2 restoring divider for the quotient by the height/width ratio
module cmrs_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      go,
	input  logic [cmrs_pkg::RAD_W-1:0] x,
	input  logic [cmrs_pkg::HW_W-1:0]  h,
	output logic                      done,
	output logic [cmrs_pkg::RAD_W-1:0] q
);
	import cmrs_pkg::*;

	localparam int unsigned NUM_W = RAD_W + 13;
	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic [HW_W-1:0]  dvs;
	logic [NUM_W-1:0] num_init;
	logic [NUM_W-1:0] num_q;
	logic [HW_W:0]    rem_q;
	logic [HW_W-1:0]  dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [HW_W:0]    trial;
	logic             fit;

	// Substitute one for a zero ratio, then add half the divisor for rounding
	assign dvs      = (h == '0) ? HW_W'(1) : h;
	assign num_init = {1'b0, x, 12'b0} + NUM_W'(dvs >> 1);

	// Bring down one dividend bit
	assign trial = {rem_q[HW_W-1:0], num_q[NUM_W-1]};
	assign fit   = (trial >= {1'b0, dvs_q});

	// Control: count quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (go) begin
			cnt_q  <= CNT_W'(NUM_W);
			run_q  <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Datapath: shift quotient bits into the dividend register
	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= num_init;
			rem_q <= '0;
			dvs_q <= dvs;
		end else if (run_q) begin
			num_q <= {num_q[NUM_W-2:0], fit};
			rem_q <= fit ? (trial - {1'b0, dvs_q}) : trial;
		end
	end

	assign done = done_q;
	assign q    = (|num_q[NUM_W-1:RAD_W]) ? ALL_ONES : num_q[RAD_W-1:0];

endmodule

// ----- sv/cmrs_datapath.sv -----
// Datapath: configuration, register file, shared multiplier, adder and divider
module cmrs_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [cmrs_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [cmrs_pkg::FAC_W-1:0]      cfg_wdata,
	input  logic [cmrs_pkg::RAD_W-1:0]      road_incident,
	input  logic [cmrs_pkg::RAD_W-1:0]      sunwall_incident,
	input  logic [cmrs_pkg::RAD_W-1:0]      shadewall_incident,
	input  logic [cmrs_pkg::FAC_W-1:0]      albedo_impervious,
	input  logic [cmrs_pkg::FAC_W-1:0]      albedo_pervious,
	input  logic [cmrs_pkg::FAC_W-1:0]      albedo_sunwall,
	input  logic [cmrs_pkg::FAC_W-1:0]      albedo_shadewall,
	input  cmrs_pkg::cmrs_cmd_t             cmd,
	output cmrs_pkg::cmrs_stat_t            stat,
	output logic [cmrs_pkg::RAD_W-1:0]      absorbed_impervious,
	output logic [cmrs_pkg::RAD_W-1:0]      absorbed_pervious,
	output logic [cmrs_pkg::RAD_W-1:0]      absorbed_sunwall,
	output logic [cmrs_pkg::RAD_W-1:0]      absorbed_shadewall,
	output logic [cmrs_pkg::RAD_W-1:0]      reflected_impervious,
	output logic [cmrs_pkg::RAD_W-1:0]      reflected_pervious,
	output logic [cmrs_pkg::RAD_W-1:0]      reflected_sunwall,
	output logic [cmrs_pkg::RAD_W-1:0]      reflected_shadewall
);
	import cmrs_pkg::*;

	localparam int unsigned PROD_W = RAD_W + FAC_W;

	logic [HW_W-1:0]  hw_q;
	logic [FAC_W-1:0] vwr_q, vrw_q, vww_q, wp_q;
	logic [RAD_W-1:0] r_q, s_q, d_q;
	logic [FAC_W-1:0] ai_q, ap_q, as_q, ad_q;
	logic [RAD_W-1:0] rf_q [RF_DEPTH];
	logic [RAD_W-1:0] rda_s1, rdb_s1;
	logic [RAD_W-1:0] crit_q;
	logic [RAD_W-1:0] out_q [OUT_NUM];

	logic [FAC_W-1:0]  wp_c, wi_c, vwr_c, vrw_c, vww_c;
	logic [RAD_W-1:0]  opa;
	logic [FAC_W-1:0]  fac;
	logic [PROD_W-1:0] prod;
	logic [PROD_W:0]   rnd16, rnd12;
	logic [RAD_W:0]    sum;
	logic [RAD_W-1:0]  mul_res, mhw_res, add_res, ex_res;
	logic              div_done;
	logic [RAD_W-1:0]  div_q;
	logic              rf_we;
	logic [RAD_W-1:0]  rf_wdata;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q  <= 16'd4096;
			vwr_q <= 17'd19195;
			vrw_q <= 17'd19195;
			vww_q <= 17'd27146;
			wp_q  <= 17'd10923;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				CFG_HW:  hw_q  <= cfg_wdata[HW_W-1:0];
				CFG_VWR: vwr_q <= cfg_wdata;
				CFG_VRW: vrw_q <= cfg_wdata;
				CFG_VWW: vww_q <= cfg_wdata;
				CFG_WP:  wp_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign wp_c  = clamp_q16(wp_q);
	assign wi_c  = Q16_ONE - wp_c;
	assign vwr_c = clamp_q16(vwr_q);
	assign vrw_c = clamp_q16(vrw_q);
	assign vww_c = clamp_q16(vww_q);

	// Capture the transaction's fields, albedos limited to one
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			r_q  <= road_incident;
			s_q  <= sunwall_incident;
			d_q  <= shadewall_incident;
			ai_q <= clamp_q16(albedo_impervious);
			ap_q <= clamp_q16(albedo_pervious);
			as_q <= clamp_q16(albedo_sunwall);
			ad_q <= clamp_q16(albedo_shadewall);
		end
	end

	// Register file read, registered
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rda_s1 <= rf_q[cmd.op.src_a];
			rdb_s1 <= rf_q[cmd.op.src_b];
		end
	end

	// Select operand A: register file or a captured incident
	always_comb begin
		case (cmd.op.ext)
			EXT_R:   opa = r_q;
			EXT_S:   opa = s_q;
			EXT_D:   opa = d_q;
			default: opa = rda_s1;
		endcase
	end

	// Select the multiplier factor
	always_comb begin
		unique case (cmd.op.fac)
			FAC_AI:  fac = ai_q;
			FAC_NAI: fac = Q16_ONE - ai_q;
			FAC_AP:  fac = ap_q;
			FAC_NAP: fac = Q16_ONE - ap_q;
			FAC_AS:  fac = as_q;
			FAC_NAS: fac = Q16_ONE - as_q;
			FAC_AD:  fac = ad_q;
			FAC_NAD: fac = Q16_ONE - ad_q;
			FAC_WP:  fac = wp_c;
			FAC_WI:  fac = wi_c;
			FAC_VWR: fac = vwr_c;
			FAC_VRW: fac = vrw_c;
			FAC_VWW: fac = vww_c;
			FAC_HW:  fac = {1'b0, hw_q};
			default: fac = '0;
		endcase
	end

	// Shared multiplier with both rounding shifts, saturating
	assign prod    = PROD_W'(opa) * PROD_W'(fac);
	assign rnd16   = {1'b0, prod} + (PROD_W+1)'(32768);
	assign rnd12   = {1'b0, prod} + (PROD_W+1)'(2048);
	assign mul_res = (|rnd16[PROD_W:RAD_W+16]) ? ALL_ONES : rnd16[RAD_W+15:16];
	assign mhw_res = (|rnd12[PROD_W:RAD_W+12]) ? ALL_ONES : rnd12[RAD_W+11:12];

	// Saturating adder
	assign sum     = {1'b0, rda_s1} + {1'b0, rdb_s1};
	assign add_res = sum[RAD_W] ? ALL_ONES : sum[RAD_W-1:0];

	always_comb begin
		case (cmd.op.kind)
			OP_MULHW: ex_res = mhw_res;
			OP_ADD:   ex_res = add_res;
			default:  ex_res = mul_res;
		endcase
	end

	cmrs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.ex && (cmd.op.kind == OP_DIV)),
		.x      (rda_s1),
		.h      (hw_q),
		.done   (div_done),
		.q      (div_q)
	);

	// Register file write
	assign rf_we    = cmd.div_wr ||
		(cmd.ex && (cmd.op.kind != OP_DIV) && (cmd.op.kind != OP_OUT));
	assign rf_wdata = cmd.div_wr ? div_q : ex_res;

	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf_q[cmd.op.dst] <= rf_wdata;
		end
	end

	// Track the largest new absorption of the pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crit_q <= '0;
		end else if (cmd.ex) begin
			case (cmd.op.crit)
				CRIT_LOAD: crit_q <= add_res;
				CRIT_MAX:  if (rdb_s1 > crit_q) crit_q <= rdb_s1;
				default:   ;
			endcase
		end
	end

	// Copy totals to the result registers
	always_ff @(posedge clk) begin
		if (cmd.ex && (cmd.op.kind == OP_OUT)) begin
			out_q[cmd.op.src_a[2:0]] <= opa;
		end
	end

	assign stat.div_done = div_done;
	assign stat.crit_low = (crit_q < ERR_LIMIT);

	assign absorbed_impervious  = out_q[0];
	assign absorbed_pervious    = out_q[1];
	assign absorbed_sunwall     = out_q[2];
	assign absorbed_shadewall   = out_q[3];
	assign reflected_impervious = out_q[4];
	assign reflected_pervious   = out_q[5];
	assign reflected_sunwall    = out_q[6];
	assign reflected_shadewall  = out_q[7];

endmodule

// ----- sv/cmrs_ctrl.sv -----
// Controller: steps through the operation sequence and the exchange passes
module cmrs_ctrl #(
	parameter int unsigned MAX_PASSES = 50
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 sun_up,
	input  cmrs_pkg::cmrs_stat_t stat,
	output cmrs_pkg::cmrs_cmd_t  cmd,
	output logic                 busy,
	output logic                 result_valid
);
	import cmrs_pkg::*;

	localparam int unsigned PASS_W = $clog2(MAX_PASSES + 1);

	typedef enum logic [1:0] {S_IDLE, S_RD, S_EX, S_DIV} state_t;

	state_t            state_q;
	step_t             step_q;
	logic [PASS_W-1:0] pass_q;
	logic              busy_q;
	logic              valid_q;
	logic              accept;
	logic              advance;
	logic              finish;
	op_t               op;

	assign op      = ucode(step_q);
	assign accept  = start && !busy_q;
	assign advance = ((state_q == S_EX) && (op.kind != OP_DIV)) ||
		((state_q == S_DIV) && stat.div_done);
	assign finish  = advance && (step_q == STEP_LAST);

	// State, step and pass counters, registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			pass_q  <= '0;
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= finish;
			unique case (state_q)
				S_IDLE: begin
					if (accept && sun_up) begin
						state_q <= S_RD;
						step_q  <= '0;
						pass_q  <= '0;
						busy_q  <= 1'b1;
					end
				end
				S_RD: state_q <= S_EX;
				S_EX, S_DIV: begin
					if (state_q == S_EX && op.kind == OP_DIV) begin
						state_q <= S_DIV;
					end else if (advance) begin
						if (step_q == STEP_LAST) begin
							state_q <= S_IDLE;
							busy_q  <= 1'b0;
						end else begin
							state_q <= S_RD;
							if (step_q == STEP_LOOP_LAST) begin
								pass_q <= pass_q + 1'b1;
								if (stat.crit_low || pass_q == PASS_W'(MAX_PASSES - 1)) begin
									step_q <= STEP_OUT_FIRST;
								end else begin
									step_q <= STEP_LOOP_FIRST;
								end
							end else begin
								step_q <= step_q + 1'b1;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Commands to the datapath
	assign cmd.op      = op;
	assign cmd.capture = accept && sun_up;
	assign cmd.rd      = (state_q == S_RD);
	assign cmd.ex      = (state_q == S_EX);
	assign cmd.div_wr  = (state_q == S_DIV) && stat.div_done;

	assign busy         = busy_q;
	assign result_valid = valid_q;

endmodule

// ----- sv/canyon_multi_reflection_solver_core.sv -----
// Top level of the urban canyon shortwave multiple reflection solver
//
//  channel   | handshake                   | payload
//  ----------+-----------------------------+---------------------------------------
//  command   | start, busy                 | sun_up, incidents, four albedos
//  result    | result_valid (1-cycle)      | four absorbed and four reflected totals
//  config    | cfg_wr_en, cfg_addr         | cfg_wdata
//
// A transaction with the sun up runs P exchange passes, P from 1 to MAX_PASSES;
// each register-file operation goes through a read and an execute state, and a
// division then waits in a divide state until the 45-bit serial divider is done.
// A transaction with the sun down is accepted but starts no work and gives no result.
// Reset clears the controller and loads the register defaults; the result strobe
// cannot be held off and the totals stay on the ports until the readout of the next
// transaction, which starts eight operations before its strobe.
`include "assert_macros.svh"

module canyon_multi_reflection_solver_core #(
	parameter int unsigned MAX_PASSES = 50
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           sun_up,
	input  logic [cmrs_pkg::RAD_W-1:0]      road_incident,
	input  logic [cmrs_pkg::RAD_W-1:0]      sunwall_incident,
	input  logic [cmrs_pkg::RAD_W-1:0]      shadewall_incident,
	input  logic [cmrs_pkg::FAC_W-1:0]      albedo_impervious,
	input  logic [cmrs_pkg::FAC_W-1:0]      albedo_pervious,
	input  logic [cmrs_pkg::FAC_W-1:0]      albedo_sunwall,
	input  logic [cmrs_pkg::FAC_W-1:0]      albedo_shadewall,
	input  logic                           cfg_wr_en,
	input  logic [cmrs_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [cmrs_pkg::FAC_W-1:0]      cfg_wdata,
	output logic                           result_valid,
	output logic [cmrs_pkg::RAD_W-1:0]      absorbed_impervious,
	output logic [cmrs_pkg::RAD_W-1:0]      absorbed_pervious,
	output logic [cmrs_pkg::RAD_W-1:0]      absorbed_sunwall,
	output logic [cmrs_pkg::RAD_W-1:0]      absorbed_shadewall,
	output logic [cmrs_pkg::RAD_W-1:0]      reflected_impervious,
	output logic [cmrs_pkg::RAD_W-1:0]      reflected_pervious,
	output logic [cmrs_pkg::RAD_W-1:0]      reflected_sunwall,
	output logic [cmrs_pkg::RAD_W-1:0]      reflected_shadewall
);
	import cmrs_pkg::*;

	cmrs_cmd_t  cmd;
	cmrs_stat_t stat;

	cmrs_ctrl #(
		.MAX_PASSES (MAX_PASSES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.sun_up       (sun_up),
		.stat         (stat),
		.cmd          (cmd),
		.busy         (busy),
		.result_valid (result_valid)
	);

	cmrs_datapath u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_wr_en            (cfg_wr_en),
		.cfg_addr             (cfg_addr),
		.cfg_wdata            (cfg_wdata),
		.road_incident        (road_incident),
		.sunwall_incident     (sunwall_incident),
		.shadewall_incident   (shadewall_incident),
		.albedo_impervious    (albedo_impervious),
		.albedo_pervious      (albedo_pervious),
		.albedo_sunwall       (albedo_sunwall),
		.albedo_shadewall     (albedo_shadewall),
		.cmd                  (cmd),
		.stat                 (stat),
		.absorbed_impervious  (absorbed_impervious),
		.absorbed_pervious    (absorbed_pervious),
		.absorbed_sunwall     (absorbed_sunwall),
		.absorbed_shadewall   (absorbed_shadewall),
		.reflected_impervious (reflected_impervious),
		.reflected_pervious   (reflected_pervious),
		.reflected_sunwall    (reflected_sunwall),
		.reflected_shadewall  (reflected_shadewall)
	);

	// A result strobe lasts one cycle and ends the work of its transaction
	`CMRS_ASSERT_NEXT(a_valid_pulse, result_valid, !result_valid)
	`CMRS_ASSERT_NOW(a_valid_idle, result_valid, !busy)
	// Sun-down transactions start no work, sun-up ones do
	`CMRS_ASSERT_NEXT(a_sun_down_idle, start && !busy && !sun_up, !busy && !result_valid)
	`CMRS_ASSERT_NEXT(a_sun_up_busy, start && !busy && sun_up, busy)

endmodule
